// File: hdl/lfid_pkg.sv
// Package for the lowest free ID allocator: field widths, codes, item types.
`default_nettype none

package lfid_pkg;

	localparam int ID_W         = 9;
	localparam int CNT_W        = 5;
	localparam int FREE_W       = 9;
	localparam int STAT_W       = 2;
	localparam int WORD_W       = 16;
	localparam int BIT_W        = $clog2(WORD_W);
	localparam int CAPACITY_DEF = 256;
	localparam int MAX_REQUEST  = 16;

	localparam logic FUNC_ALLOC   = 1'b0;
	localparam logic FUNC_RELEASE = 1'b1;

	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_SHORT = 2'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;
	localparam logic [STAT_W-1:0] STAT_RANGE = 2'd3;

	typedef struct packed {
		logic              func;
		logic [CNT_W-1:0]  count;
		logic [ID_W-1:0]   release_id;
	} req_t;

	typedef struct packed {
		logic              [ID_W-1:0]   granted_id;
		logic                           last;
		logic              [STAT_W-1:0] status;
		logic              [FREE_W-1:0] free_count;
	} rsp_t;

endpackage

`default_nettype wire

// File: hdl/lfid_map_ram.sv
// In-use bitmap memory: one write and one registered read port, rows read as zero until written.
`default_nettype none

module lfid_map_ram
	import lfid_pkg::*;
#(
	parameter int ROWS = 16,
	localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              rd_en,
	input  wire logic [ROW_W-1:0]  rd_row,
	output logic      [WORD_W-1:0] rd_word,
	input  wire logic              wr_en,
	input  wire logic [ROW_W-1:0]  wr_row,
	input  wire logic [WORD_W-1:0] wr_word
);

	logic [WORD_W-1:0] mem [ROWS];
	logic [ROWS-1:0]   row_vld_q;
	logic [WORD_W-1:0] rd_data_q;
	logic              rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_row] <= wr_word;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_row];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rd_vld_q  <= 1'b0;
		end else begin
			if (wr_en) begin
				row_vld_q[wr_row] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= row_vld_q[rd_row];
			end
		end
	end

	assign rd_word = rd_vld_q ? rd_data_q : '0;

endmodule

`default_nettype wire

// File: hdl/lowest_free_id_allocator_unit.sv
// Top level of the lowest free ID allocator: request sequencer, bitmap memory and result register.
//
// Channel  Valid      Stall      Payload  Direction
// request  req_valid  req_stall  req      into the block
// result   rsp_valid  rsp_stall  rsp      out of the block
//
// A rejected or empty item passes through the reply state; a release reads its bitmap row,
// then clears the bit, if set, in the release state. An allocate reads the first bitmap row,
// loads each row it visits, grants its IDs one at a time and writes back each full row it passes.
// The scan starts at the lowest row that may hold a free ID, so the rows visited depend on the map.
// Reset clears the row valid flags at once; there is no clearing pass.
// A stalled result holds the sequencer wherever it would load a result; one item is worked on at a time.
`default_nettype none

module lowest_free_id_allocator_unit
	import lfid_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_stall,
	output rsp_t      rsp
);

	localparam int ROWS    = (CAPACITY + WORD_W - 1) / WORD_W;
	localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int FREE_IW = $clog2(CAPACITY + 1);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_REPLY = 5'b00010,
		ST_REL   = 5'b00100,
		ST_LOAD  = 5'b01000,
		ST_GRANT = 5'b10000
	} state_t;

	function automatic logic [WORD_W-1:0] pad_mask(input logic [ROW_W-1:0] r);
		logic [WORD_W-1:0] m;
		m = '0;
		for (int b = 0; b < WORD_W; b++) begin
			m[b] = ((32'(r) << BIT_W) + 32'(b)) >= 32'(CAPACITY);
		end
		return m;
	endfunction

	state_t             st_q, st_d;
	logic [FREE_IW-1:0] free_q, free_d;
	logic [ROW_W-1:0]   hint_q, hint_d;
	logic [ROW_W-1:0]   row_q, row_d;
	logic [BIT_W-1:0]   bit_q, bit_d;
	logic [CNT_W-1:0]   rem_q, rem_d;
	logic [WORD_W-1:0]  wrk_q, wrk_d;
	rsp_t               pend_q, pend_d;
	logic               out_vld_q;
	rsp_t               out_q, out_d;
	logic               out_load;
	logic               out_free;

	logic               rd_en;
	logic [ROW_W-1:0]   rd_row;
	logic [WORD_W-1:0]  rd_word;
	logic               wr_en;
	logic [ROW_W-1:0]   wr_row;
	logic [WORD_W-1:0]  wr_word;

	logic [31:0]        rid32;
	logic [31:0]        idx32;
	logic               rid_bad;
	logic [ROW_W-1:0]   rel_row;
	logic [BIT_W-1:0]   rel_bit;
	logic [BIT_W-1:0]   sel;
	logic [WORD_W-1:0]  wrk_n;
	logic [FREE_IW-1:0] free_n;
	logic [31:0]        id32;

	lfid_map_ram #(
		.ROWS(ROWS)
	) u_map (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_row  (rd_row),
		.rd_word (rd_word),
		.wr_en   (wr_en),
		.wr_row  (wr_row),
		.wr_word (wr_word)
	);

	assign out_free  = !out_vld_q || !rsp_stall;
	assign req_stall = (st_q != ST_IDLE);
	assign rsp_valid = out_vld_q;
	assign rsp       = out_q;

	assign rid32   = 32'(req.release_id);
	assign idx32   = rid32 - 32'd1;
	assign rid_bad = (rid32 == 32'd0) || (rid32 > 32'(CAPACITY));
	assign rel_row = ROW_W'(idx32 >> BIT_W);
	assign rel_bit = idx32[BIT_W-1:0];

	always_comb begin
		sel = '0;
		for (int b = WORD_W - 1; b >= 0; b--) begin
			if (!wrk_q[b]) begin
				sel = BIT_W'(b);
			end
		end
	end

	assign wrk_n = wrk_q | (WORD_W'(1) << sel);
	assign id32  = (32'(row_q) << BIT_W) + 32'(sel) + 32'd1;

	always_comb begin
		st_d     = st_q;
		free_d   = free_q;
		hint_d   = hint_q;
		row_d    = row_q;
		bit_d    = bit_q;
		rem_d    = rem_q;
		wrk_d    = wrk_q;
		pend_d   = pend_q;
		out_d    = out_q;
		out_load = 1'b0;
		rd_en    = 1'b0;
		rd_row   = hint_q;
		wr_en    = 1'b0;
		wr_row   = row_q;
		wr_word  = wrk_q;
		free_n   = free_q;
		case (st_q)
			ST_IDLE: begin
				if (req_valid) begin
					if (req.func == FUNC_RELEASE) begin
						if (rid_bad) begin
							pend_d = '{ID_W'(0), 1'b1, STAT_RANGE, FREE_W'(free_q)};
							st_d   = ST_REPLY;
						end else begin
							rd_en  = 1'b1;
							rd_row = rel_row;
							row_d  = rel_row;
							bit_d  = rel_bit;
							st_d   = ST_REL;
						end
					end else if (req.count == '0) begin
						pend_d = '{ID_W'(0), 1'b1, STAT_EMPTY, FREE_W'(free_q)};
						st_d   = ST_REPLY;
					end else if ((32'(req.count) > 32'(MAX_REQUEST)) ||
						(32'(req.count) > 32'(free_q))) begin
						pend_d = '{ID_W'(0), 1'b1, STAT_SHORT, FREE_W'(free_q)};
						st_d   = ST_REPLY;
					end else begin
						rd_en  = 1'b1;
						rd_row = hint_q;
						row_d  = hint_q;
						rem_d  = req.count;
						st_d   = ST_LOAD;
					end
				end
			end
			ST_REPLY: begin
				if (out_free) begin
					out_load = 1'b1;
					out_d    = pend_q;
					st_d     = ST_IDLE;
				end
			end
			ST_REL: begin
				if (out_free) begin
					if (rd_word[bit_q]) begin
						wr_en   = 1'b1;
						wr_row  = row_q;
						wr_word = rd_word & ~(WORD_W'(1) << bit_q);
						free_n  = FREE_IW'(free_q + 1'b1);
						if (row_q < hint_q) begin
							hint_d = row_q;
						end
					end
					free_d   = free_n;
					out_load = 1'b1;
					out_d    = '{ID_W'(0), 1'b1, STAT_OK, FREE_W'(free_n)};
					st_d     = ST_IDLE;
				end
			end
			ST_LOAD: begin
				wrk_d = rd_word | pad_mask(row_q);
				st_d  = ST_GRANT;
			end
			ST_GRANT: begin
				if (&wrk_q) begin
					wr_en   = 1'b1;
					wr_row  = row_q;
					wr_word = wrk_q;
					row_d   = ROW_W'(row_q + 1'b1);
					rd_en   = 1'b1;
					rd_row  = ROW_W'(row_q + 1'b1);
					st_d    = ST_LOAD;
				end else if (out_free) begin
					free_n   = FREE_IW'(free_q - 1'b1);
					free_d   = free_n;
					wrk_d    = wrk_n;
					rem_d    = CNT_W'(rem_q - 1'b1);
					out_load = 1'b1;
					out_d    = '{ID_W'(id32), (rem_q == CNT_W'(1)), STAT_OK, FREE_W'(free_n)};
					if (rem_q == CNT_W'(1)) begin
						wr_en   = 1'b1;
						wr_row  = row_q;
						wr_word = wrk_n;
						hint_d  = row_q;
						st_d    = ST_IDLE;
					end
				end
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			free_q    <= FREE_IW'(CAPACITY);
			hint_q    <= '0;
			rem_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			st_q   <= st_d;
			free_q <= free_d;
			hint_q <= hint_d;
			rem_q  <= rem_d;
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		row_q  <= row_d;
		bit_q  <= bit_d;
		wrk_q  <= wrk_d;
		pend_q <= pend_d;
		if (out_load) begin
			out_q <= out_d;
		end
	end

	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(free_q) <= 32'(CAPACITY))
		else $error("free count exceeds capacity");

	a_grant_has_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_GRANT && out_load) |-> rem_q != '0)
		else $error("grant issued with no IDs left to hand out");

	a_release_count: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_REL && wr_en) |=> 32'(free_q) == 32'($past(free_q)) + 32'd1)
		else $error("release write-back did not raise the free count");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_GRANT && rd_en) |-> 32'(row_q) + 32'd1 < 32'(ROWS))
		else $error("scan ran past the last bitmap row");

endmodule

`default_nettype wire
